// ===== hdl/i64a_pkg.sv =====
// ----------------------------------------------------------------------------
// i64a_pkg
// Shared types, constants and the double-dabble step for int64_to_decimal_ascii.
// ----------------------------------------------------------------------------
`default_nettype none

package i64a_pkg;

  localparam int MAX_DIGITS      = 20;
  localparam int BCD_W           = 4 * MAX_DIGITS;
  localparam int MAG_W           = 64;
  localparam int STEPS_PER_STAGE = 8;
  localparam int NUM_STAGES      = MAG_W / STEPS_PER_STAGE;
  localparam int IDX_W           = 5;

  localparam logic [5:0] CODE_MINUS = 6'd45;
  localparam logic [5:0] CODE_ZERO  = 6'd48;

  typedef struct packed {
    logic               neg;
    logic [MAG_W-1:0]   mag;
    logic [BCD_W-1:0]   bcd;
  } dd_word_t;

  // One double-dabble shift: correct every digit of 5 or more, then shift in a bit.
  function automatic logic [BCD_W-1:0] dd_step(input logic [BCD_W-1:0] bcd,
                                                input logic in_bit);
    logic [BCD_W-1:0] adj;
    adj = bcd;
    for (int k = 0; k < MAX_DIGITS; k++) begin
      if (bcd[4*k +: 4] >= 4'd5) begin
        adj[4*k +: 4] = bcd[4*k +: 4] + 4'd3;
      end
    end
    return {adj[BCD_W-2:0], in_bit};
  endfunction

endpackage

`default_nettype wire

// ===== hdl/i64a_dd_stage.sv =====
// ----------------------------------------------------------------------------
// i64a_dd_stage
// One pipeline stage that performs a fixed number of double-dabble shifts.
// ----------------------------------------------------------------------------
`default_nettype none

module i64a_dd_stage (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire i64a_pkg::dd_word_t in_data,
  output logic                    in_ready,
  output logic                    out_valid,
  output i64a_pkg::dd_word_t      out_data,
  input  wire logic               out_ready
);
  import i64a_pkg::*;

  dd_word_t work;

  always_comb begin
    work = in_data;
    for (int s = 0; s < STEPS_PER_STAGE; s++) begin
      work.bcd = dd_step(work.bcd, work.mag[MAG_W-1]);
      work.mag = {work.mag[MAG_W-2:0], 1'b0};
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= work;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/i64a_emitter.sv =====
// ----------------------------------------------------------------------------
// i64a_emitter
// Serializes a converted BCD word into ASCII characters, one per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module i64a_emitter (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire i64a_pkg::dd_word_t in_data,
  output logic                    in_ready,
  output logic                    strobe,
  output logic [5:0]              char_code,
  output logic                    last_char
);
  import i64a_pkg::*;

  logic               active;
  logic               sign_pending;
  logic [IDX_W-1:0]   idx;
  logic [BCD_W-1:0]   bcd;
  logic [IDX_W-1:0]   top_next;
  logic [3:0]         digit;

  // Highest nonzero digit; zero leaves index 0 so a lone '0' is sent.
  always_comb begin
    top_next = '0;
    for (int k = 1; k < MAX_DIGITS; k++) begin
      if (in_data.bcd[4*k +: 4] != 4'd0) begin
        top_next = IDX_W'(k);
      end
    end
  end

  assign in_ready = !active;
  assign digit    = bcd[4*idx +: 4];

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      strobe <= 1'b0;
    end else if (!active) begin
      active <= in_valid;
      strobe <= 1'b0;
    end else begin
      strobe <= 1'b1;
      if (!sign_pending && idx == '0) begin
        active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!active) begin
      sign_pending <= in_data.neg;
      idx          <= top_next;
      bcd          <= in_data.bcd;
    end else if (sign_pending) begin
      sign_pending <= 1'b0;
      char_code    <= CODE_MINUS;
      last_char    <= 1'b0;
    end else begin
      char_code <= CODE_ZERO + {2'b00, digit};
      last_char <= (idx == '0);
      if (idx != '0) begin
        idx <= idx - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/int64_to_decimal_ascii.sv =====
// ----------------------------------------------------------------------------
// int64_to_decimal_ascii
// Signed 64-bit integer to decimal ASCII text, most significant char first.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken at a rising edge where start is high and busy is low;
//   value carries the signed two's complement integer.
//   The text leaves on char_code, one character per cycle, each marked by a
//   one-cycle strobe; last_char is high on the final character. A negative
//   value starts with '-', zero gives a single '0', no leading zeros.
// Pipeline:
//   The magnitude passes eight pipeline stages of eight double-dabble shifts
//   each, then the emitter. The emitter takes a new number only once it has
//   sent the last character of the one before and so sets the sustained
//   rate; the stages buffer up to eight queued requests, so busy rises only
//   when they fill.
// Reset:
//   rst (synchronous) empties the pipeline and the emitter; no strobe follows.
// The receiver cannot stall: every strobed character must be taken.
// ----------------------------------------------------------------------------
`default_nettype none

module int64_to_decimal_ascii (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [63:0] value,
  output logic             strobe,
  output logic [5:0]       char_code,
  output logic             last_char
);
  import i64a_pkg::*;

  dd_word_t   head;
  dd_word_t   data  [NUM_STAGES+1];
  logic       valid [NUM_STAGES+1];
  logic       ready [NUM_STAGES+1];

  always_comb begin
    head.neg = value[63];
    head.mag = value[63] ? (64'd0 - value) : value;
    head.bcd = '0;
  end

  assign data[0]  = head;
  assign valid[0] = start;
  assign busy     = !ready[0];

  for (genvar g = 0; g < NUM_STAGES; g++) begin : g_stage
    i64a_dd_stage u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (valid[g]),
      .in_data   (data[g]),
      .in_ready  (ready[g]),
      .out_valid (valid[g+1]),
      .out_data  (data[g+1]),
      .out_ready (ready[g+1])
    );
  end

  i64a_emitter u_emitter (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (valid[NUM_STAGES]),
    .in_data   (data[NUM_STAGES]),
    .in_ready  (ready[NUM_STAGES]),
    .strobe    (strobe),
    .char_code (char_code),
    .last_char (last_char)
  );

endmodule

`default_nettype wire

// ===== hdl/i64a_checker.sv =====
// ----------------------------------------------------------------------------
// i64a_checker
// Port-level checks on the character stream of int64_to_decimal_ascii.
// ----------------------------------------------------------------------------
`default_nettype none

module i64a_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        start,
  input wire logic        busy,
  input wire logic [63:0] value,
  input wire logic        strobe,
  input wire logic [5:0]  char_code,
  input wire logic        last_char
);
  import i64a_pkg::*;

  // Only a minus sign or a decimal digit ever leaves the block.
  assert property (@(posedge clk) disable iff (rst)
    strobe |-> (char_code == CODE_MINUS ||
                (char_code >= CODE_ZERO && char_code <= CODE_ZERO + 6'd9)))
    else $error("illegal character code");

  // A number's text runs without gaps until its last character.
  assert property (@(posedge clk) disable iff (rst)
    strobe && !last_char |=> strobe)
    else $error("gap inside a number's text");

  // A minus sign is never the end and is not followed by another minus sign.
  assert property (@(posedge clk) disable iff (rst)
    strobe && char_code == CODE_MINUS |-> !last_char ##1 (char_code != CODE_MINUS))
    else $error("misplaced minus sign");

  // Reset leaves no character on the output and the block ready for a request.
  assert property (@(posedge clk) rst |=> !strobe && !busy)
    else $error("strobe or busy after reset");

  // An accepted request carries a fully defined value.
  assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> !$isunknown(value))
    else $error("unknown value on an accepted request");

endmodule

bind int64_to_decimal_ascii i64a_checker u_i64a_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .value     (value),
  .strobe    (strobe),
  .char_code (char_code),
  .last_char (last_char)
);

`default_nettype wire
